### rtl/ips_pkg.sv
package ips_pkg;

    // Ring geometry
    localparam int WINDOW = 16;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Item field widths
    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int SCNT_W = 5;

    // Sum of up to WINDOW entries of DATA_W bits
    localparam int SUM_W  = DATA_W + CNT_W;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
    localparam logic [OP_W-1:0] OP_EVAL  = 2'd3;

    // Elapsed ticks with wrap rule; equal reads give all ones
    function automatic logic [DATA_W-1:0] wrap_span(
        input logic [DATA_W-1:0] from_t,
        input logic [DATA_W-1:0] to_t
    );
        logic [DATA_W-1:0] span;
        if (to_t > from_t)
        begin
            span = to_t - from_t;
        end
        else
        begin
            span = ~(from_t - to_t);
        end
        return span;
    endfunction

endpackage

### rtl/ips_event_if.sv
interface ips_event_if
    import ips_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] timestamp;
    logic [DATA_W-1:0] calib_timestamp;

    modport source (output valid, output opcode, output timestamp,
                    output calib_timestamp, input ready);
    modport sink   (input valid, input opcode, input timestamp,
                    input calib_timestamp, output ready);
endinterface

### rtl/ips_stats_if.sv
interface ips_stats_if
    import ips_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SCNT_W-1:0] sample_count;
    logic [DATA_W-1:0] min_time;
    logic [DATA_W-1:0] max_time;
    logic [DATA_W-1:0] mean_time;

    modport source (output valid, output sample_count, output min_time,
                    output max_time, output mean_time, input ready);
    modport sink   (input valid, input sample_count, input min_time,
                    input max_time, input mean_time, output ready);
endinterface

### rtl/ips_div.sv
module ips_div
    import ips_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;

    logic [CNT_W:0]    shifted;
    logic              fits;
    logic [CNT_W:0]    diff;

    // One quotient bit per cycle: shift in next dividend bit, trial subtract
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = (shifted >= {1'b0, divisor});
    assign diff    = shifted - {1'b0, divisor};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DATA_W-1:0];

endmodule

### rtl/interval_profiler_stats_core.sv
// Clear and start items end on acceptance, stop items pass through S_STORE, and
// evaluate walks n entries (S_FETCH, S_ACC each), then the divider (S_DIV, S_WAIT)
// and S_FINISH, reached at once on an empty ring and held while an earlier result
// waits. Input ready is low while an item is in progress; one item at a time.
// Reset (rst_n, async, active low) clears statistics and control; the ring
// contents are undefined until written.
module interval_profiler_stats_core
    import ips_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ips_event_if.sink    events,
    ips_stats_if.source  stats
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STORE  = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [DATA_W-1:0] start_time_reg;
    logic [DATA_W-1:0] overhead_reg;
    logic [DATA_W-1:0] count_reg;
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0] mean_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [DATA_W-1:0] span_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [SCNT_W-1:0] out_count_reg;
    logic [DATA_W-1:0] out_min_reg;
    logic [DATA_W-1:0] out_max_reg;
    logic [DATA_W-1:0] out_mean_reg;

    logic [DATA_W-1:0] ring [WINDOW];

    logic              accept;
    logic              ring_we;
    logic [DATA_W-1:0] ring_wdata;
    logic [CNT_W-1:0]  n_now;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    assign accept     = events.valid && events.ready;
    assign ring_we    = (state_reg == S_STORE);
    assign ring_wdata = span_reg - overhead_reg;
    assign n_now      = (count_reg < DATA_W'(WINDOW)) ? count_reg[CNT_W-1:0]
                                                       : CNT_W'(WINDOW);
    assign out_free   = !out_valid_reg || stats.ready;
    assign div_start  = (state_reg == S_DIV);

    assign events.ready = (state_reg == S_IDLE);

    // Bit-serial divider for the mean
    ips_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (events.opcode)
                        OP_STOP: state_next = S_STORE;
                        OP_EVAL: state_next = (n_now == '0) ? S_FINISH : S_FETCH;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_STORE:  state_next = S_IDLE;
            S_FETCH:  state_next = S_ACC;
            S_ACC:    state_next = (idx_reg + 1'b1 == n_reg) ? S_DIV : S_FETCH;
            S_DIV:    state_next = S_WAIT;
            S_WAIT:   state_next = div_done ? S_FINISH : S_WAIT;
            S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_time_reg <= '0;
            overhead_reg   <= '0;
            count_reg      <= '0;
            wr_ptr_reg     <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            mean_reg       <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Raise the result when loaded, drop it once taken
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats.valid && stats.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                case (events.opcode)
                    OP_CLEAR:
                    begin
                        start_time_reg <= '0;
                        overhead_reg   <= '0;
                        count_reg      <= '0;
                        wr_ptr_reg     <= '0;
                        min_reg        <= '1;
                        max_reg        <= '0;
                        mean_reg       <= '0;
                    end
                    OP_START:
                    begin
                        if (overhead_reg == '0)
                        begin
                            overhead_reg <= wrap_span(events.timestamp,
                                                      events.calib_timestamp);
                        end
                        start_time_reg <= events.timestamp;
                    end
                    OP_EVAL:
                    begin
                        idx_reg <= '0;
                        if (n_now == '0)
                        begin
                            mean_reg <= '0;
                        end
                    end
                    default:
                    begin
                        idx_reg <= idx_reg;
                    end
                endcase
            end

            // Advance the write slot; restart it after the last slot or when the count wraps
            if (ring_we)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '1 || wr_ptr_reg == IDX_W'(WINDOW - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end

            // Fold one entry into min and max and step the walk index
            if (state_reg == S_ACC)
            begin
                if (rd_data_reg > max_reg)
                begin
                    max_reg <= rd_data_reg;
                end
                if (rd_data_reg < min_reg)
                begin
                    min_reg <= rd_data_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end

            if (state_reg == S_WAIT && div_done)
            begin
                mean_reg <= div_quotient;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && events.opcode == OP_STOP)
        begin
            span_reg <= wrap_span(start_time_reg, events.timestamp);
        end
        if (accept && events.opcode == OP_EVAL)
        begin
            n_reg   <= n_now;
            sum_reg <= '0;
        end
        if (state_reg == S_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (state_reg == S_FINISH && out_free)
        begin
            out_count_reg <= SCNT_W'(n_reg);
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_mean_reg  <= mean_reg;
        end
    end

    // Interval ring: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[wr_ptr_reg] <= ring_wdata;
        end
        rd_data_reg <= ring[idx_reg[IDX_W-1:0]];
    end

    assign stats.valid        = out_valid_reg;
    assign stats.sample_count = out_count_reg;
    assign stats.min_time     = out_min_reg;
    assign stats.max_time     = out_max_reg;
    assign stats.mean_time    = out_mean_reg;

endmodule

### bench/tb_interval_profiler_stats_core.sv
module tb_interval_profiler_stats_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ips_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [SCNT_W-1:0] sample_count;
        logic [DATA_W-1:0] min_time;
        logic [DATA_W-1:0] max_time;
        logic [DATA_W-1:0] mean_time;
    } stats_t;

    // Tracks profiler state and holds the statistics still to come out
    class profiler_scoreboard;
        stats_t            stats_q[$];
        int unsigned       errors;
        logic [DATA_W-1:0] start_ts;
        logic [DATA_W-1:0] overhead;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] ring [WINDOW];
        logic [DATA_W-1:0] run_min;
        logic [DATA_W-1:0] run_max;
        logic [DATA_W-1:0] mean;

        function new();
            errors = 0;
            clear_stats();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
        endfunction

        function void clear_stats();
            start_ts = '0;
            overhead = '0;
            count    = '0;
            run_min  = '1;
            run_max  = '0;
            mean     = '0;
        endfunction

        // Ticks between two reads; equal reads count as a full wrap
        function logic [DATA_W-1:0] elapsed(logic [DATA_W-1:0] t0, logic [DATA_W-1:0] t1);
            logic [DATA_W-1:0] d;
            if (t1 > t0)
            begin
                d = t1 - t0;
            end
            else
            begin
                d = 32'hFFFF_FFFF - (t0 - t1);
            end
            return d;
        endfunction

        // Advance the state by one accepted item, queue statistics on evaluate
        function void note_event(logic [OP_W-1:0] op, logic [DATA_W-1:0] ts,
                                 logic [DATA_W-1:0] cal);
            logic [DATA_W-1:0] n;
            logic [63:0]       sum;
            stats_t            s;
            n   = '0;
            sum = '0;
            case (op)
                OP_CLEAR:
                begin
                    clear_stats();
                end
                OP_START:
                begin
                    if (overhead == '0)
                    begin
                        overhead = elapsed(ts, cal);
                    end
                    start_ts = ts;
                end
                OP_STOP:
                begin
                    ring[count % WINDOW] = elapsed(start_ts, ts) - overhead;
                    count = count + 1;
                end
                default:
                begin
                    n = (count < WINDOW) ? count : WINDOW;
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        if (ring[i] > run_max)
                        begin
                            run_max = ring[i];
                        end
                        if (ring[i] < run_min)
                        begin
                            run_min = ring[i];
                        end
                        sum += ring[i];
                    end
                    mean = (n != 0) ? DATA_W'(sum / n) : '0;
                    s.sample_count = n[SCNT_W-1:0];
                    s.min_time     = run_min;
                    s.max_time     = run_max;
                    s.mean_time    = mean;
                    stats_q.push_back(s);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_stats(stats_t got);
            stats_t want;
            if (stats_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result cnt=%0d min=%h max=%h mean=%h",
                                          got.sample_count, got.min_time, got.max_time,
                                          got.mean_time));
            end
            else
            begin
                want = stats_q.pop_front();
                if (got.sample_count !== want.sample_count)
                begin
                    report_mismatch($sformatf("sample_count got %0d want %0d",
                                              got.sample_count, want.sample_count));
                end
                if (got.min_time !== want.min_time)
                begin
                    report_mismatch($sformatf("min_time got %h want %h",
                                              got.min_time, want.min_time));
                end
                if (got.max_time !== want.max_time)
                begin
                    report_mismatch($sformatf("max_time got %h want %h",
                                              got.max_time, want.max_time));
                end
                if (got.mean_time !== want.mean_time)
                begin
                    report_mismatch($sformatf("mean_time got %h want %h",
                                              got.mean_time, want.mean_time));
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycle_count;
    int unsigned send_calm;

    ips_event_if ev_ch ();
    ips_stats_if st_ch ();

    profiler_scoreboard sb = new();

    interval_profiler_stats_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (ev_ch),
        .stats  (st_ch)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        int unsigned g;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            g = 0;
        end
        else if (r < 85)
        begin
            g = $urandom_range(1, 3);
        end
        else if (r < 96)
        begin
            g = $urandom_range(4, 12);
        end
        else
        begin
            g = $urandom_range(20, 60);
        end
        return g;
    endfunction

    // Any opcode, for noise items
    function automatic logic [OP_W-1:0] OP_OP_W_rand();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(0, 3));
        return op;
    endfunction

    // Offer one item after an optional gap, hold it until accepted
    task automatic send_event(logic [OP_W-1:0] op, logic [DATA_W-1:0] ts,
                              logic [DATA_W-1:0] cal);
        int unsigned gap;
        gap = 0;
        if (send_calm > 0)
        begin
            send_calm--;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            send_calm = 60;
        end
        else
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_ch.valid           <= 1'b1;
        ev_ch.opcode          <= op;
        ev_ch.timestamp       <= ts;
        ev_ch.calib_timestamp <= cal;
        @(posedge clk);
        while (!ev_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_event(op, ts, cal);
    endtask

    // Accept results with random stalls and two long hold-offs
    initial
    begin : stats_sink
        int unsigned seen;
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned hold_left;
        int unsigned next_hold;
        int unsigned holds_done;
        stats_t      got;
        seen       = 0;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        next_hold  = 30;
        holds_done = 0;
        st_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && st_ch.valid && st_ch.ready)
            begin
                got.sample_count = st_ch.sample_count;
                got.min_time     = st_ch.min_time;
                got.max_time     = st_ch.max_time;
                got.mean_time    = st_ch.mean_time;
                sb.check_stats(got);
                seen++;
            end
            if (holds_done < 2 && seen >= next_hold && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                next_hold = seen + 100;
                holds_done++;
            end
            if (!rst_n)
            begin
                st_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                st_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                st_ch.ready <= 1'b0;
            end
            else
            begin
                st_ch.ready <= 1'b1;
                if (calm_left > 0)
                begin
                    calm_left--;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    calm_left = 80;
                end
                else
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Reset, directed items, random items, drain
    initial
    begin : stimulus
        int unsigned       sent;
        int unsigned       r;
        logic [DATA_W-1:0] t0;
        logic [DATA_W-1:0] t1;
        sent        = 0;
        send_calm   = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        ev_ch.valid           <= 1'b0;
        ev_ch.opcode          <= OP_CLEAR;
        ev_ch.timestamp       <= '0;
        ev_ch.calib_timestamp <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Evaluate on an empty ring right after reset
        send_event(OP_EVAL, 32'h0, 32'h0);
        // Calibration that gives zero overhead, so the next start calibrates again
        send_event(OP_START, 32'hFFFF_FFFF, 32'h0);
        // Equal calibration reads give an all-ones overhead
        send_event(OP_START, 32'h0, 32'h0);
        // Equal start and stop give a full wrap
        send_event(OP_STOP, 32'h0, 32'hFFFF_FFFF);
        send_event(OP_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Ordinary calibration and interval
        send_event(OP_START, 32'd1000, 32'd1010);
        send_event(OP_STOP, 32'd1500, 32'h5555_5555);
        // Calibration skipped once overhead is set; stop wraps past the start
        send_event(OP_START, 32'hFFFF_FFF0, 32'd5);
        send_event(OP_STOP, 32'h0000_0010, 32'h0);
        // Interval shorter than the overhead wraps below zero
        send_event(OP_START, 32'd200, 32'h0);
        send_event(OP_STOP, 32'd205, 32'h0);
        send_event(OP_START, 32'h0, 32'hAAAA_AAAA);
        send_event(OP_STOP, 32'hFFFF_FFFF, 32'h0);
        send_event(OP_EVAL, 32'h0, 32'h0);
        send_event(OP_CLEAR, 32'h0, 32'h0);
        // Calibration with the second read behind the first
        send_event(OP_START, 32'd50, 32'd20);
        send_event(OP_STOP, 32'd49, 32'h0);
        send_event(OP_EVAL, 32'h0, 32'h0);
        // Clear keeps the ring, evaluate sees no entries
        send_event(OP_CLEAR, 32'h0, 32'h0);
        send_event(OP_EVAL, 32'h0, 32'h0);

        // Random phase: mostly start/stop pairs with evaluates, some noise
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                t0 = $urandom();
                if ($urandom_range(0, 9) == 0)
                begin
                    t1 = $urandom();
                end
                else
                begin
                    t1 = t0 + $urandom_range(1, 40);
                end
                send_event(OP_START, t0, t1);
                if ($urandom_range(0, 9) == 0)
                begin
                    t1 = $urandom();
                end
                else
                begin
                    t1 = t0 + $urandom_range(0, 5000);
                end
                send_event(OP_STOP, t1, $urandom());
                sent += 2;
            end
            else if (r < 78)
            begin
                send_event(OP_EVAL, $urandom(), $urandom());
                sent++;
            end
            else if (r < 81)
            begin
                send_event(OP_CLEAR, $urandom(), $urandom());
                sent++;
            end
            else if (r < 89)
            begin
                send_event(OP_STOP, $urandom(), $urandom());
                sent++;
            end
            else if (r < 94)
            begin
                send_event(OP_START, $urandom(), $urandom());
                sent++;
            end
            else
            begin
                send_event(OP_OP_W_rand(), $urandom(), $urandom());
                sent++;
            end
        end
        ev_ch.valid <= 1'b0;

        // Drain outstanding statistics
        while (sb.stats_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ips_pkg.sv
rtl/ips_event_if.sv
rtl/ips_stats_if.sv
rtl/ips_div.sv
rtl/interval_profiler_stats_core.sv
bench/tb_interval_profiler_stats_core.sv
